// File: sv/spfl_pkg.sv
// Shared constants for the slot pool free-list allocator.
// Pool geometry, derived index widths and command codes.
// Depends on nothing; used by the top level by scoped names.
package spfl_pkg;

	localparam int POOL_SIZE = 64;
	localparam int SLOT_W    = $clog2(POOL_SIZE);
	// One more bit than a slot index so that POOL_SIZE itself marks the empty list.
	localparam int LINK_W    = SLOT_W + 1;
	localparam int POS_W     = 16;
	localparam int KEY_W     = 3 * POS_W;
	localparam int CMD_W     = 2;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;

endpackage

// File: sv/slot_pool_free_list_with_key_lookup_top.sv
// Slot pool allocator: LIFO free list, per-slot active bit and 48-bit position key.
// Allocate passes ST_LINK then ST_RESP; release or a rejected command goes straight to ST_RESP;
// find walks the slots from zero in ST_SCAN until a hit or the end of the pool, and the position
// memory port reads one slot a cycle. A command is taken only in ST_IDLE, once the last is through.
// Reset: asynchronous, active low; pool_entries is 64, slots 0..n-1 chained, none active.
// Link entries not written since the last rebuild read as their chained default, so no sweep.
// Depends on spfl_pkg.
module slot_pool_free_list_with_key_lookup_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spfl_pkg::APB_AW-1:0]         paddr,
	input  logic [spfl_pkg::APB_DW-1:0]         pwdata,
	output logic [spfl_pkg::APB_DW-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [spfl_pkg::CMD_W-1:0]          command,
	input  logic signed [spfl_pkg::POS_W-1:0]   pos_x,
	input  logic signed [spfl_pkg::POS_W-1:0]   pos_y,
	input  logic signed [spfl_pkg::POS_W-1:0]   pos_z,
	input  logic [spfl_pkg::SLOT_W-1:0]         slot_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [spfl_pkg::SLOT_W-1:0]         slot_out
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LINK = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	localparam logic [spfl_pkg::LINK_W-1:0] EMPTY = spfl_pkg::LINK_W'(spfl_pkg::POOL_SIZE);

	state_t                              state_q;
	logic [spfl_pkg::LINK_W-1:0]         pool_entries_q;
	logic [spfl_pkg::LINK_W-1:0]         free_head_q;
	logic [spfl_pkg::POOL_SIZE-1:0]      active_q;
	logic [spfl_pkg::POOL_SIZE-1:0]      link_valid_q;
	logic [spfl_pkg::SLOT_W-1:0]         scan_q;
	logic [spfl_pkg::KEY_W-1:0]          key_q;
	logic                                res_ok_q;
	logic [spfl_pkg::SLOT_W-1:0]         res_slot_q;
	logic                                out_valid_q;
	logic                                ok_q;
	logic [spfl_pkg::SLOT_W-1:0]         slot_out_q;

	logic [spfl_pkg::LINK_W-1:0]         link_mem [spfl_pkg::POOL_SIZE];
	logic [spfl_pkg::KEY_W-1:0]          pos_mem  [spfl_pkg::POOL_SIZE];
	logic [spfl_pkg::LINK_W-1:0]         link_rdata_q;
	logic [spfl_pkg::KEY_W-1:0]          pos_rdata_q;

	logic                                in_fire;
	logic                                cfg_wr;
	logic [spfl_pkg::LINK_W-1:0]         cfg_raw;
	logic [spfl_pkg::LINK_W-1:0]         cfg_sat;
	logic                                pool_empty;
	logic                                rel_ok;
	logic                                pos_we;
	logic                                link_we;
	logic [spfl_pkg::SLOT_W-1:0]         pos_raddr;
	logic [spfl_pkg::LINK_W-1:0]         scan_next;
	logic                                scan_hit;
	logic [spfl_pkg::LINK_W-1:0]         succ;
	logic [spfl_pkg::LINK_W-1:0]         link_dflt;
	logic                                out_load;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
	assign cfg_raw = pwdata[spfl_pkg::LINK_W-1:0];
	always_comb begin
		priority if (cfg_raw == '0) begin
			cfg_sat = spfl_pkg::LINK_W'(1);
		end else if (cfg_raw > EMPTY) begin
			cfg_sat = EMPTY;
		end else begin
			cfg_sat = cfg_raw;
		end
	end
	assign prdata = {{(spfl_pkg::APB_DW-spfl_pkg::LINK_W){1'b0}}, pool_entries_q};

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign pool_empty = (free_head_q == EMPTY);
	assign rel_ok     = ({1'b0, slot_in} < pool_entries_q) && active_q[slot_in];

	assign pos_we    = in_fire && (command == spfl_pkg::CMD_ALLOC) && !pool_empty;
	assign link_we   = in_fire && (command == spfl_pkg::CMD_RELEASE) && rel_ok;
	assign scan_next = {1'b0, scan_q} + spfl_pkg::LINK_W'(1);
	// While idle the first scan read is already issued at slot zero.
	assign pos_raddr = (state_q == ST_SCAN) ? scan_next[spfl_pkg::SLOT_W-1:0] : '0;
	assign scan_hit  = active_q[scan_q] && (pos_rdata_q == key_q);

	// A link never written since the last rebuild holds its chained default.
	assign succ      = {1'b0, res_slot_q} + spfl_pkg::LINK_W'(1);
	assign link_dflt = (succ < pool_entries_q) ? succ : EMPTY;

	assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[free_head_q[spfl_pkg::SLOT_W-1:0]] <= {pos_x, pos_y, pos_z};
		end
		pos_rdata_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[slot_in] <= free_head_q;
		end
		link_rdata_q <= link_mem[free_head_q[spfl_pkg::SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= {pos_x, pos_y, pos_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pool_entries_q <= EMPTY;
			free_head_q    <= '0;
			active_q       <= '0;
			link_valid_q   <= '0;
			scan_q         <= '0;
			res_ok_q       <= 1'b0;
			res_slot_q     <= '0;
		end else begin
			if (cfg_wr) begin
				pool_entries_q <= cfg_sat;
				free_head_q    <= '0;
				active_q       <= '0;
				link_valid_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_ok_q   <= 1'b0;
						res_slot_q <= '0;
						state_q    <= ST_RESP;
						unique case (command)
							spfl_pkg::CMD_ALLOC: begin
								if (!pool_empty) begin
									active_q[free_head_q[spfl_pkg::SLOT_W-1:0]] <= 1'b1;
									res_ok_q   <= 1'b1;
									res_slot_q <= free_head_q[spfl_pkg::SLOT_W-1:0];
									state_q    <= ST_LINK;
								end
							end
							spfl_pkg::CMD_RELEASE: begin
								if (rel_ok) begin
									link_valid_q[slot_in] <= 1'b1;
									active_q[slot_in]     <= 1'b0;
									free_head_q           <= {1'b0, slot_in};
									res_ok_q              <= 1'b1;
									res_slot_q            <= slot_in;
								end
							end
							spfl_pkg::CMD_FIND: begin
								scan_q  <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LINK: begin
					free_head_q <= link_valid_q[res_slot_q] ? link_rdata_q : link_dflt;
					state_q     <= ST_RESP;
				end
				ST_SCAN: begin
					priority if (scan_hit) begin
						res_ok_q   <= 1'b1;
						res_slot_q <= scan_q;
						state_q    <= ST_RESP;
					end else if (scan_next >= pool_entries_q) begin
						state_q <= ST_RESP;
					end else begin
						scan_q <= scan_next[spfl_pkg::SLOT_W-1:0];
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: a finished beat waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_q       <= res_ok_q;
			slot_out_q <= res_slot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign slot_out  = slot_out_q;

	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("accepted beat did not start processing");

	a_fail_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> slot_out_q == '0)
		else $error("failed result carries a nonzero slot");

	a_head_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q != EMPTY |-> free_head_q < pool_entries_q)
		else $error("free list head outside the pool");

	a_alloc_marked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINK |-> active_q[res_slot_q])
		else $error("allocated slot not marked active");

	a_rebuild_head: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> free_head_q == '0)
		else $error("rebuild did not reset the free list head");

endmodule
